### hdl/tdq_pkg.sv
// Shared types and constants for the timer deadline queue.
`default_nettype none
package tdq_pkg;

	localparam int TIME_W = 64;
	localparam int ID_W = 8;
	localparam logic [TIME_W-1:0] TIME_INFINITE = '1;
	localparam int CMD_FIFO_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_PREEMPT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPORT
	} back_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   timer_id;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] now;
	} cmd_t;

	typedef struct packed {
		logic              expired_valid;
		logic [ID_W-1:0]   expired_id;
		logic              preempt_fired;
		logic              program_valid;
		logic [TIME_W-1:0] program_deadline;
		logic              overflow;
		logic              last;
	} result_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} cell_stat_t;

endpackage
`default_nettype wire

### hdl/tdq_front.sv
// Input side: accepts items, drops unused kinds and buffers commands.
`default_nettype none
module tdq_front
	import tdq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic [135:0] s_tdata,
	input  wire logic [1:0] s_tuser,
	output logic      cmd_valid,
	output cmd_t      cmd,
	input  wire logic cmd_pop
);

	localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t             mem_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             known_kind;
	logic             push;
	logic             pop;
	cmd_t             cmd_in;

	always_comb begin
		known_kind = (s_tuser == KIND_INSERT) || (s_tuser == KIND_TICK) ||
			(s_tuser == KIND_PREEMPT);
		s_tready = (cnt_q != CNT_W'(CMD_FIFO_DEPTH));
		push = s_tvalid && s_tready && known_kind;
		cmd_valid = (cnt_q != '0);
		pop = cmd_pop && cmd_valid;
		cmd = mem_q[rd_ptr_q];
		cmd_in.kind = kind_t'(s_tuser);
		cmd_in.timer_id = s_tdata[7:0];
		cmd_in.deadline = s_tdata[71:8];
		cmd_in.now = s_tdata[135:72];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/tdq_cells.sv
// Sorted shifting cell chain that holds the pending timers.
`default_nettype none
module tdq_cells
	import tdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic [TIME_W-1:0] new_deadline,
	input  wire logic [ID_W-1:0] new_id,
	output cell_stat_t stat,
	output logic [TIME_W-1:0] head_deadline,
	output logic [ID_W-1:0] head_id
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [TIME_W-1:0] dl_q [QUEUE_DEPTH];
	logic [ID_W-1:0]   id_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [QUEUE_DEPTH-1:0] stay;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign stay[i] = (CNT_W'(i) < count_q) && (dl_q[i] <= new_deadline);

		always_ff @(posedge clk) begin
			if (ctrl.ins) begin
				if (!stay[i]) begin
					if (i == 0) begin
						dl_q[i] <= new_deadline;
						id_q[i] <= new_id;
					end else if (stay[(i == 0) ? 0 : i - 1]) begin
						dl_q[i] <= new_deadline;
						id_q[i] <= new_id;
					end else begin
						dl_q[i] <= dl_q[(i == 0) ? 0 : i - 1];
						id_q[i] <= id_q[(i == 0) ? 0 : i - 1];
					end
				end
			end else if (ctrl.pop) begin
				if (i < QUEUE_DEPTH - 1) begin
					dl_q[i] <= dl_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
					id_q[i] <= id_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.ins) begin
			count_q <= count_q + 1'b1;
		end else if (ctrl.pop) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_comb begin
		stat.empty = (count_q == '0);
		stat.full = (count_q == CNT_W'(QUEUE_DEPTH));
		head_deadline = dl_q[0];
		head_id = id_q[0];
	end

endmodule
`default_nettype wire

### hdl/tdq_back.sv
// Command sequencer: runs inserts, ticks and preemption resets, owns the result register.
`default_nettype none
module tdq_back
	import tdq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	input  wire cmd_t cmd,
	output logic      cmd_pop,
	output cell_ctrl_t ctrl,
	input  wire cell_stat_t stat,
	input  wire logic [TIME_W-1:0] head_deadline,
	input  wire logic [ID_W-1:0] head_id,
	output logic      res_valid,
	output result_t   res,
	input  wire logic res_ready
);

	back_state_t       state_q, state_n;
	logic [TIME_W-1:0] preempt_q, preempt_n;
	logic [TIME_W-1:0] pending_q, pending_n;
	logic [TIME_W-1:0] now_q, now_n;
	logic              fired_q, fired_n;
	logic              ovf_q, ovf_n;
	logic              out_valid_q;
	result_t           out_q, out_n;
	logic              out_load;
	logic              out_free;
	logic [TIME_W-1:0] next_dl;

	assign out_free = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res = out_q;

	always_comb begin
		state_n = state_q;
		preempt_n = preempt_q;
		pending_n = pending_q;
		now_n = now_q;
		fired_n = fired_q;
		ovf_n = ovf_q;
		out_n = '0;
		out_load = 1'b0;
		cmd_pop = 1'b0;
		ctrl = '0;
		next_dl = (!stat.empty && (head_deadline < preempt_q)) ? head_deadline : preempt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					unique case (cmd.kind)
						KIND_INSERT: begin
							ctrl.ins = !stat.full;
							ovf_n = stat.full;
							fired_n = 1'b0;
							state_n = ST_REPORT;
						end
						KIND_TICK: begin
							fired_n = (cmd.now >= preempt_q);
							preempt_n = (cmd.now >= preempt_q) ? TIME_INFINITE : preempt_q;
							pending_n = TIME_INFINITE;
							now_n = cmd.now;
							ovf_n = 1'b0;
							state_n = ST_SCAN;
						end
						KIND_PREEMPT: begin
							preempt_n = cmd.deadline;
							out_load = 1'b1;
							out_n.last = 1'b1;
							if ((cmd.deadline != TIME_INFINITE) && (cmd.deadline < pending_q)) begin
								pending_n = cmd.deadline;
								out_n.program_valid = 1'b1;
								out_n.program_deadline = cmd.deadline;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!stat.empty && (head_deadline <= now_q)) begin
					if (out_free) begin
						ctrl.pop = 1'b1;
						out_load = 1'b1;
						out_n.expired_valid = 1'b1;
						out_n.expired_id = head_id;
						out_n.preempt_fired = fired_q;
					end
				end else begin
					state_n = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					pending_n = next_dl;
					out_load = 1'b1;
					out_n.preempt_fired = fired_q;
					out_n.program_valid = 1'b1;
					out_n.program_deadline = next_dl;
					out_n.overflow = ovf_q;
					out_n.last = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			preempt_q <= TIME_INFINITE;
			pending_q <= TIME_INFINITE;
			fired_q <= 1'b0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			preempt_q <= preempt_n;
			pending_q <= pending_n;
			fired_q <= fired_n;
			ovf_q <= ovf_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		now_q <= now_n;
		if (out_load) begin
			out_q <= out_n;
		end
	end

endmodule
`default_nettype wire

### hdl/timer_deadline_queue_core.sv
// Top level of the timer deadline queue: front buffer, sequencer and cell chain.
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid / s_tready  tdata: timer_id, deadline, now; tuser: kind
// m_*      out  m_tvalid / m_tready  tdata: expired_id, program_deadline; tuser: flags; tlast
//
// An insert shifts the cell chain from the idle state and then reports the next
// deadline from the report state. A preemption reset is answered from the idle state
// alone. A tick pops one expired head per cycle while the result register is free,
// then reports once the head is not yet due. A two-entry command buffer
// lets input items arrive while the sequencer works or the result waits.
// Reset clears the count, flags and deadlines at once; no clearing pass is needed.
`default_nettype none
module timer_deadline_queue_core
	import tdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire logic [135:0] s_tdata, // timer_id[7:0], deadline[71:8], now[135:72]
	input  wire logic [1:0] s_tuser,   // kind[1:0]
	output logic      m_tvalid,
	input  wire logic m_tready,
	output logic [71:0] m_tdata,       // expired_id[7:0], program_deadline[71:8]
	output logic [3:0] m_tuser,        // expired_valid, preempt_fired, program_valid, overflow
	output logic      m_tlast
);

	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;
	cell_ctrl_t        ctrl;
	cell_stat_t        stat;
	logic [TIME_W-1:0] head_deadline;
	logic [ID_W-1:0]   head_id;
	result_t           res;

	tdq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	tdq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.ctrl         (ctrl),
		.stat         (stat),
		.head_deadline(head_deadline),
		.head_id      (head_id),
		.res_valid    (m_tvalid),
		.res          (res),
		.res_ready    (m_tready)
	);

	tdq_cells #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_cells (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.new_deadline (cmd.deadline),
		.new_id       (cmd.timer_id),
		.stat         (stat),
		.head_deadline(head_deadline),
		.head_id      (head_id)
	);

	assign m_tdata = {res.program_deadline, res.expired_id};
	assign m_tuser = {res.overflow, res.program_valid, res.preempt_fired, res.expired_valid};
	assign m_tlast = res.last;

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.pop && stat.empty))
		else $error("pop from an empty queue");

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && stat.full))
		else $error("insert into a full queue");

	a_ins_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && ctrl.pop))
		else $error("insert and pop in the same cycle");

	a_expired_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[2] && !m_tlast)
		else $error("expired item carries programming or last");

endmodule
`default_nettype wire
